FILE: rtl/hsv_to_rgb_convert_macros.svh
// Assertion macros used by the checker file.
`ifndef HSV_TO_RGB_CONVERT_MACROS_SVH
`define HSV_TO_RGB_CONVERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define HSV2RGB_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define HSV2RGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

	typedef logic [15:0] q15_t;

	localparam q15_t        Q15_ONE      = 16'h8000;
	localparam logic [30:0] Q15_HALF     = 31'd16384;
	localparam logic [15:0] HUE_TURN     = 16'd46080;
	localparam logic [12:0] HUE_SECTOR   = 13'd7680;
	localparam logic [27:0] SECTOR_HALF  = 28'd3840;

	// floor(y / 15) = (y * RECIP_15) >> RECIP_SHIFT, exact for y < 2^19
	localparam logic [19:0] RECIP_15     = 20'd559241;
	localparam int          RECIP_SHIFT  = 23;

	// hue sectors, 60 degrees each
	localparam logic [2:0] SEC_RED_YEL = 3'd0;
	localparam logic [2:0] SEC_YEL_GRN = 3'd1;
	localparam logic [2:0] SEC_GRN_CYN = 3'd2;
	localparam logic [2:0] SEC_CYN_BLU = 3'd3;
	localparam logic [2:0] SEC_BLU_MAG = 3'd4;
	localparam logic [2:0] SEC_MAG_RED = 3'd5;

	typedef struct packed {
		logic [2:0]  sector;
		logic [12:0] rem;
	} hue_split_t;

endpackage

`default_nettype wire

FILE: rtl/hsv2rgb_if.sv
`default_nettype none

interface hsv_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] hue;
	logic [15:0] saturation;
	logic [15:0] brightness;
	logic [15:0] alpha_in;

	modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
	modport sink   (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

interface rgb_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic [15:0] alpha_out;

	modport source (output valid, red, green, blue, alpha_out, input ready);
	modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/hsv_to_rgb_convert.sv
// Channel   Dir  Words carried
// --------  ---  ---------------------------------------------
// pix_in    in   hue, saturation, brightness, alpha_in
// pix_out   out  red, green, blue, alpha_out
//
// Five-stage pipeline: one pixel per clock while pix_out is not stalled. An
// accepted word moves through stages 1 to 4 into the stage-5 output register.
// The stages hold the two multiplier layers (fraction times saturation,
// then value times the complement) and the reciprocal multiply that divides
// by one sector width.
// arst_n clears every stage valid bit; data registers are not reset.
// A stall on pix_out backs up only through full stages; empty stages keep
// filling, so pix_in stays ready until the whole pipe is full.
`default_nettype none

module hsv_to_rgb_convert
	import hsv2rgb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hsv_in_if.sink     pix_in,
	rgb_out_if.source  pix_out
);

	// per-stage valid bits and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	// a stage loads when it is empty or its content moves on
	assign en5 = !vld_s5 || pix_out.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign pix_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= pix_in.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// ---------------- stage 1: clamp, wrap hue, sector split ----------------
	hue_split_t split;

	hsv2rgb_sector u_sector (
		.hue   (pix_in.hue),
		.split (split)
	);

	q15_t        sat_s1, val_s1, alpha_s1;
	logic [2:0]  sector_s1;
	logic [12:0] rem_s1;

	always_ff @(posedge clk) begin
		if (en1 && pix_in.valid) begin
			sat_s1    <= (pix_in.saturation > Q15_ONE) ? Q15_ONE : pix_in.saturation;
			val_s1    <= (pix_in.brightness > Q15_ONE) ? Q15_ONE : pix_in.brightness;
			alpha_s1  <= pix_in.alpha_in;
			sector_s1 <= split.sector;
			rem_s1    <= split.rem;
		end
	end

	// ---------------- stage 2: S*r, S*(7680-r), V*(1-S) ----------------
	// Rounding constants are folded in here. Zero saturation needs no
	// special path: P, Q and T all come out equal to V.
	logic [12:0] rem_c;
	logic [27:0] mul_f, mul_fc;
	logic [30:0] mul_p;

	assign rem_c  = HUE_SECTOR - rem_s1;
	assign mul_f  = ({12'd0, sat_s1} * {15'd0, rem_s1}) + SECTOR_HALF;
	assign mul_fc = ({12'd0, sat_s1} * {15'd0, rem_c}) + SECTOR_HALF;
	assign mul_p  = ({15'd0, val_s1} * {15'd0, Q15_ONE - sat_s1}) + Q15_HALF;

	logic [27:0] prod_f_s2, prod_fc_s2;
	logic [30:0] prod_p_s2;
	q15_t        val_s2, alpha_s2;
	logic [2:0]  sector_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_f_s2  <= mul_f;
			prod_fc_s2 <= mul_fc;
			prod_p_s2  <= mul_p;
			val_s2     <= val_s1;
			alpha_s2   <= alpha_s1;
			sector_s2  <= sector_s1;
		end
	end

	// ---------------- stage 3: divide by 7680 = 512 * 15 ----------------
	// shift out 512, then multiply by the reciprocal of 15
	logic [38:0] quo_f, quo_fc;

	assign quo_f  = {20'd0, prod_f_s2[27:9]}  * {19'd0, RECIP_15};
	assign quo_fc = {20'd0, prod_fc_s2[27:9]} * {19'd0, RECIP_15};

	logic [38:0] quo_f_s3, quo_fc_s3;
	q15_t        p_s3, val_s3, alpha_s3;
	logic [2:0]  sector_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			quo_f_s3  <= quo_f;
			quo_fc_s3 <= quo_fc;
			p_s3      <= prod_p_s2[30:15];
			val_s3    <= val_s2;
			alpha_s3  <= alpha_s2;
			sector_s3 <= sector_s2;
		end
	end

	// ---------------- stage 4: V*(1-S*F), V*(1-S*(1-F)) ----------------
	q15_t        sf, sfc;
	logic [30:0] mul_q, mul_t;

	assign sf    = quo_f_s3[RECIP_SHIFT +: 16];
	assign sfc   = quo_fc_s3[RECIP_SHIFT +: 16];
	assign mul_q = ({15'd0, val_s3} * {15'd0, Q15_ONE - sf})  + Q15_HALF;
	assign mul_t = ({15'd0, val_s3} * {15'd0, Q15_ONE - sfc}) + Q15_HALF;

	logic [30:0] prod_q_s4, prod_t_s4;
	q15_t        p_s4, val_s4, alpha_s4;
	logic [2:0]  sector_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			prod_q_s4 <= mul_q;
			prod_t_s4 <= mul_t;
			p_s4      <= p_s3;
			val_s4    <= val_s3;
			alpha_s4  <= alpha_s3;
			sector_s4 <= sector_s3;
		end
	end

	// ---------------- stage 5: channel select, output register ----------------
	q15_t q_val, t_val;
	q15_t red_d, green_d, blue_d;

	assign q_val = prod_q_s4[30:15];
	assign t_val = prod_t_s4[30:15];

	always_comb begin
		case (sector_s4)
			SEC_RED_YEL: begin red_d = val_s4; green_d = t_val;  blue_d = p_s4;   end
			SEC_YEL_GRN: begin red_d = q_val;  green_d = val_s4; blue_d = p_s4;   end
			SEC_GRN_CYN: begin red_d = p_s4;   green_d = val_s4; blue_d = t_val;  end
			SEC_CYN_BLU: begin red_d = p_s4;   green_d = q_val;  blue_d = val_s4; end
			SEC_BLU_MAG: begin red_d = t_val;  green_d = p_s4;   blue_d = val_s4; end
			// magenta-red sector and unused codes
			default:     begin red_d = val_s4; green_d = p_s4;   blue_d = q_val;  end
		endcase
	end

	q15_t red_s5, green_s5, blue_s5, alpha_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= red_d;
			green_s5 <= green_d;
			blue_s5  <= blue_d;
			alpha_s5 <= alpha_s4;
		end
	end

	assign pix_out.valid     = vld_s5;
	assign pix_out.red       = red_s5;
	assign pix_out.green     = green_s5;
	assign pix_out.blue      = blue_s5;
	assign pix_out.alpha_out = alpha_s5;

endmodule

`default_nettype wire

FILE: rtl/hsv2rgb_sector.sv
`default_nettype none

// Wraps hue once past 360 degrees, then splits it into sector and offset.
module hsv2rgb_sector
	import hsv2rgb_pkg::*;
(
	input  wire logic [15:0] hue,
	output hue_split_t       split
);

	localparam logic [15:0] B1 = 16'd7680;
	localparam logic [15:0] B2 = 16'd15360;
	localparam logic [15:0] B3 = 16'd23040;
	localparam logic [15:0] B4 = 16'd30720;
	localparam logic [15:0] B5 = 16'd38400;

	logic [15:0] h_wrap;
	logic [15:0] base;
	logic [15:0] offs;

	assign h_wrap = (hue >= HUE_TURN) ? (hue - HUE_TURN) : hue;

	always_comb begin
		if (h_wrap >= B5) begin
			split.sector = SEC_MAG_RED;
			base         = B5;
		end else if (h_wrap >= B4) begin
			split.sector = SEC_BLU_MAG;
			base         = B4;
		end else if (h_wrap >= B3) begin
			split.sector = SEC_CYN_BLU;
			base         = B3;
		end else if (h_wrap >= B2) begin
			split.sector = SEC_GRN_CYN;
			base         = B2;
		end else if (h_wrap >= B1) begin
			split.sector = SEC_YEL_GRN;
			base         = B1;
		end else begin
			split.sector = SEC_RED_YEL;
			base         = 16'd0;
		end
		offs      = h_wrap - base;
		split.rem = offs[12:0];
	end

endmodule

`default_nettype wire

FILE: rtl/hsv2rgb_checker.sv
`default_nettype none

`include "hsv_to_rgb_convert_macros.svh"

module hsv2rgb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] red,
	input wire logic [15:0] green,
	input wire logic [15:0] blue,
	input wire logic [15:0] alpha_out
);

	localparam logic [2:0] DEPTH = 3'd5;

	logic        in_acc, out_acc;
	logic [2:0]  inflight_q;
	logic [63:0] out_word;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign out_word = {red, green, blue, alpha_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	`HSV2RGB_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !out_valid, "output valid in reset")

	`HSV2RGB_ASSERT(a_no_phantom, clk, arst_n, out_valid |-> inflight_q != 3'd0, "word with no input")

	`HSV2RGB_ASSERT(a_depth, clk, arst_n, inflight_q <= DEPTH, "more words in flight than stages")

	`HSV2RGB_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_word)), "stalled word changed")

endmodule

bind hsv_to_rgb_convert hsv2rgb_checker u_hsv2rgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.red       (pix_out.red),
	.green     (pix_out.green),
	.blue      (pix_out.blue),
	.alpha_out (pix_out.alpha_out)
);

`default_nettype wire
